// File: design/assert_macros.svh
// Assertion macros shared by the key extractor RTL.
// Needs nothing else; the files that check their logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on each rising edge of clk, ignored while rst is high.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check prop on each rising edge of clk, reset cycles included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: design/jtke_pkg.sv
// Types and character codes for the JSON top-level key extractor.
// No dependencies; used by jtke_parser and json_top_key_extractor.
`default_nettype none

package jtke_pkg;

   typedef logic [7:0] byte_type;

   // Parser modes
   typedef enum logic [3:0] {
      MODE_SEEK_OPEN  = 4'd0,
      MODE_BETWEEN    = 4'd1,
      MODE_KEY        = 4'd2,
      MODE_SEEK_COLON = 4'd3,
      MODE_SKIP_SPACE = 4'd4,
      MODE_OBJ        = 4'd5,
      MODE_ARR        = 4'd6,
      MODE_STR        = 4'd7,
      MODE_STR_ESC    = 4'd8,
      MODE_SCALAR     = 4'd9,
      MODE_DONE       = 4'd10
   } mode_type;

   // One parse result; has_result says whether it is delivered at all
   typedef struct packed {
      logic     has_result;
      byte_type key_char;
      logic     char_valid;
      logic     key_end;
      logic     doc_done;
   } result_type;

   // Characters the parser looks for
   localparam byte_type CH_LBRACE    = 8'h7B;
   localparam byte_type CH_RBRACE    = 8'h7D;
   localparam byte_type CH_LBRACKET  = 8'h5B;
   localparam byte_type CH_RBRACKET  = 8'h5D;
   localparam byte_type CH_COLON     = 8'h3A;
   localparam byte_type CH_COMMA     = 8'h2C;
   localparam byte_type CH_BACKSLASH = 8'h5C;
   localparam byte_type CH_QUOTE     = 8'h22;
   localparam byte_type CH_SPACE     = 8'h20;

endpackage

`default_nettype wire

// File: design/jtke_parser.sv
// Parse state of the key extractor: mode and nesting registers plus the
// per-byte step logic. Depends on jtke_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module jtke_parser
   import jtke_pkg::*;
#(
   parameter int MAX_NEST = 255
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step_en,
   input  wire byte_type   text_byte,
   input  wire logic       last_byte,
   output result_type      result
);

   localparam int NEST_W = $clog2(MAX_NEST + 1);
   localparam logic [NEST_W-1:0] NEST_MAX = NEST_W'(MAX_NEST);
   localparam logic [NEST_W-1:0] NEST_ONE = NEST_W'(1);

   mode_type          mode_ff, mode_in, mode_step;
   logic [NEST_W-1:0] nest_ff, nest_in, nest_step, nest_dec;
   logic              cv, kend, done;

   // State registers, advanced once per byte
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SEEK_OPEN;
         nest_ff <= '0;
      end else if (step_en) begin
         mode_ff <= mode_in;
         nest_ff <= nest_in;
      end
   end

   // Decrement that stops at zero
   assign nest_dec = (nest_ff != '0) ? nest_ff - NEST_ONE : nest_ff;

   // Mode transition for one byte
   always_comb begin
      mode_step = mode_ff;
      nest_step = nest_ff;
      cv        = 1'b0;
      kend      = 1'b0;
      done      = 1'b0;
      unique case (mode_ff)
         MODE_BETWEEN: begin
            if (text_byte == CH_RBRACE) begin
               done      = 1'b1;
               mode_step = MODE_DONE;
            end else if (text_byte == CH_QUOTE) begin
               mode_step = MODE_KEY;
            end
         end
         MODE_KEY: begin
            if (text_byte == CH_QUOTE) begin
               kend      = 1'b1;
               mode_step = MODE_SEEK_COLON;
            end else begin
               cv = 1'b1;
            end
         end
         MODE_SEEK_COLON: begin
            if (text_byte == CH_COLON) mode_step = MODE_SKIP_SPACE;
         end
         MODE_SKIP_SPACE: begin
            priority if (text_byte == CH_SPACE) begin
               mode_step = MODE_SKIP_SPACE;
            end else if (text_byte == CH_LBRACE) begin
               nest_step = NEST_ONE;
               mode_step = MODE_OBJ;
            end else if (text_byte == CH_LBRACKET) begin
               nest_step = NEST_ONE;
               mode_step = MODE_ARR;
            end else if (text_byte == CH_QUOTE) begin
               mode_step = MODE_STR;
            end else if (text_byte == CH_COMMA) begin
               mode_step = MODE_BETWEEN;
            end else if (text_byte == CH_RBRACE) begin
               done      = 1'b1;
               mode_step = MODE_DONE;
            end else begin
               mode_step = MODE_SCALAR;
            end
         end
         MODE_OBJ: begin
            if (text_byte == CH_LBRACE) begin
               if (nest_ff < NEST_MAX) nest_step = nest_ff + NEST_ONE;
            end else if (text_byte == CH_RBRACE) begin
               nest_step = nest_dec;
               if (nest_dec == '0) mode_step = MODE_BETWEEN;
            end
         end
         MODE_ARR: begin
            if (text_byte == CH_LBRACKET) begin
               if (nest_ff < NEST_MAX) nest_step = nest_ff + NEST_ONE;
            end else if (text_byte == CH_RBRACKET) begin
               nest_step = nest_dec;
               if (nest_dec == '0) mode_step = MODE_BETWEEN;
            end
         end
         MODE_STR: begin
            if (text_byte == CH_BACKSLASH) mode_step = MODE_STR_ESC;
            else if (text_byte == CH_QUOTE) mode_step = MODE_BETWEEN;
         end
         MODE_STR_ESC: mode_step = MODE_STR;
         MODE_SCALAR: begin
            if (text_byte == CH_COMMA) begin
               mode_step = MODE_BETWEEN;
            end else if (text_byte == CH_RBRACE) begin
               done      = 1'b1;
               mode_step = MODE_DONE;
            end
         end
         MODE_DONE: mode_step = MODE_DONE;
         default: begin
            // seek opening brace, and codes that are never used
            if (text_byte == CH_LBRACE) mode_step = MODE_BETWEEN;
         end
      endcase
   end

   // End of document: close an open key, flag done once, restart
   always_comb begin
      mode_in           = mode_step;
      nest_in           = nest_step;
      result.key_char   = cv ? text_byte : '0;
      result.char_valid = cv;
      result.key_end    = kend | (last_byte & (mode_step == MODE_KEY));
      result.doc_done   = done | (last_byte & (mode_step != MODE_DONE));
      if (last_byte) begin
         mode_in = MODE_SEEK_OPEN;
         nest_in = '0;
      end
      result.has_result = result.char_valid | result.key_end | result.doc_done;
   end

   `ASSERT_PROP(a_nest_bounded, clock, reset, nest_ff <= NEST_MAX)
   `ASSERT_PROP(a_last_restarts, clock, reset,
      (step_en && last_byte) |=> (mode_ff == MODE_SEEK_OPEN && nest_ff == '0))
   `ASSERT_ALWAYS(a_reset_restarts, clock,
      reset |=> (mode_ff == MODE_SEEK_OPEN && nest_ff == '0))

endmodule

`default_nettype wire

// File: design/json_top_key_extractor.sv
// Top level of the JSON top-level key extractor: input register, parser,
// result register. Depends on jtke_pkg, jtke_parser and assert_macros.svh.
//
//   channel  | direction | payload
//   req_     | in        | tdata = text_byte, tlast = last_byte
//   rsp_     | out       | tdata = key_char, tlast = key_end,
//            |           | tuser = char_valid, doc_done
//
// One byte per clock is accepted and parsed while no result is stalled;
// a byte goes from the input register through the parser mode step into
// the result register, from which its result can leave.
// Bytes that cause no result leave nothing behind.
// Reset (synchronous) returns the parser to seeking the opening brace and
// empties both registers. A stalled result holds the pipeline; req_tready
// drops only while the input register is full and cannot move on.
`default_nettype none
`include "assert_macros.svh"

module json_top_key_extractor
   import jtke_pkg::*;
#(
   parameter int MAX_NEST = 255
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] text_byte
   input  wire logic       req_tlast,   // last_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] key_char
   output logic            rsp_tlast,   // key_end
   output logic [1:0]      rsp_tuser    // [0] char_valid, [1] doc_done
);

   logic       in_valid_ff, in_valid_in;
   byte_type   in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type step_res;
   logic       out_free, step_en, req_take;

   // Handshake control
   assign out_free    = !out_valid_ff || rsp_tready;
   assign step_en     = in_valid_ff && out_free;
   assign req_tready  = !in_valid_ff || out_free;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !out_free);
   assign out_valid_in = step_en ? step_res.has_result : (out_valid_ff && !rsp_tready);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   jtke_parser #(
      .MAX_NEST (MAX_NEST)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .text_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (step_res)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (step_en && step_res.has_result) out_ff <= step_res;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.key_char;
   assign rsp_tlast  = out_ff.key_end;
   assign rsp_tuser  = {out_ff.doc_done, out_ff.char_valid};

   `ASSERT_PROP(a_result_nonempty, clock, reset,
      out_valid_ff |-> (out_ff.char_valid || out_ff.key_end || out_ff.doc_done))
   `ASSERT_PROP(a_char_zero_idle, clock, reset,
      (out_valid_ff && !out_ff.char_valid) |-> (out_ff.key_char == '0))
   `ASSERT_PROP(a_input_held, clock, reset,
      (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(in_byte_ff)
                                      && $stable(in_last_ff)))

endmodule

`default_nettype wire

// File: tb/tb_json_top_key_extractor.sv
// Self-checking testbench for json_top_key_extractor: directed documents, then random ones.
// Depends on jtke_pkg and the RTL under design/; predicts every result in-line.
`default_nettype none

module tb_json_top_key_extractor;
   import jtke_pkg::*;

   localparam int NEST_LIMIT  = 255;
   localparam int CYCLE_LIMIT = 600000;
   localparam int TARGET_BYTES = 1250;

   // One row of the directed table; pinned rows carry a hand-typed expectation
   typedef struct {
      byte_type   text;
      bit         lst;
      bit         pinned;
      result_type want;
   } row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] text_byte
   logic       req_tlast = 1'b0;    // last_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] key_char
   logic       rsp_tlast;           // key_end
   logic [1:0] rsp_tuser;           // [0] char_valid, [1] doc_done

   // Shadow parser state
   mode_type   shadow_mode = MODE_SEEK_OPEN;
   logic [7:0] shadow_nest = 8'd0;

   result_type expected_results[$];
   byte_type   doc_text[$];
   row_type    directed_rows[26];

   int cycle_count = 0;
   int mismatch_count = 0;
   int bytes_sent = 0;
   int docs_sent = 0;
   int results_checked = 0;
   int chars_seen = 0;
   int ends_seen = 0;
   int dones_seen = 0;
   int burst_left = 0;
   bit calm_doc = 1'b0;
   int stall_style = 0;
   int stall_left = 0;

   json_top_key_extractor #(.MAX_NEST(NEST_LIMIT)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // Cycle count and watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  expected_results.size());
         $display("tb_json_top_key_extractor: errors");
         $finish;
      end
   end

   // Append one byte to the document being built
   function automatic void add_text(byte_type b);
      doc_text.insert(doc_text.size(), b);
   endfunction

   // Queue one expected result behind the older ones
   function automatic void add_expect(result_type r);
      expected_results.insert(expected_results.size(), r);
   endfunction

   function automatic result_type key_result(byte_type kc, bit cv, bit ke, bit dd);
      result_type r;
      r = '{has_result: 1'b1, key_char: kc, char_valid: cv, key_end: ke, doc_done: dd};
      return r;
   endfunction

   // Advance the shadow parser by one byte and return what it emits
   function automatic result_type parse_byte(byte_type c, bit lst);
      result_type r;
      r = '0;
      case (shadow_mode)
         MODE_BETWEEN: begin
            if (c == CH_RBRACE) begin
               r.doc_done = 1'b1;
               shadow_mode = MODE_DONE;
            end else if (c == CH_QUOTE) begin
               shadow_mode = MODE_KEY;
            end
         end
         MODE_KEY: begin
            if (c == CH_QUOTE) begin
               r.key_end = 1'b1;
               shadow_mode = MODE_SEEK_COLON;
            end else begin
               r.char_valid = 1'b1;
               r.key_char = c;
            end
         end
         MODE_SEEK_COLON: begin
            if (c == CH_COLON) shadow_mode = MODE_SKIP_SPACE;
         end
         MODE_SKIP_SPACE: begin
            if (c == CH_SPACE) begin
               // stay
            end else if (c == CH_LBRACE) begin
               shadow_nest = 8'd1;
               shadow_mode = MODE_OBJ;
            end else if (c == CH_LBRACKET) begin
               shadow_nest = 8'd1;
               shadow_mode = MODE_ARR;
            end else if (c == CH_QUOTE) begin
               shadow_mode = MODE_STR;
            end else if (c == CH_COMMA) begin
               shadow_mode = MODE_BETWEEN;
            end else if (c == CH_RBRACE) begin
               r.doc_done = 1'b1;
               shadow_mode = MODE_DONE;
            end else begin
               shadow_mode = MODE_SCALAR;
            end
         end
         MODE_OBJ, MODE_ARR: begin
            // depth count saturates at the nesting limit
            if (c == ((shadow_mode == MODE_OBJ) ? CH_LBRACE : CH_LBRACKET)) begin
               if (shadow_nest < NEST_LIMIT) shadow_nest = shadow_nest + 8'd1;
            end else if (c == ((shadow_mode == MODE_OBJ) ? CH_RBRACE : CH_RBRACKET)) begin
               if (shadow_nest != 8'd0) shadow_nest = shadow_nest - 8'd1;
               if (shadow_nest == 8'd0) shadow_mode = MODE_BETWEEN;
            end
         end
         MODE_STR: begin
            if (c == CH_BACKSLASH) shadow_mode = MODE_STR_ESC;
            else if (c == CH_QUOTE) shadow_mode = MODE_BETWEEN;
         end
         MODE_STR_ESC: shadow_mode = MODE_STR;
         MODE_SCALAR: begin
            if (c == CH_COMMA) begin
               shadow_mode = MODE_BETWEEN;
            end else if (c == CH_RBRACE) begin
               r.doc_done = 1'b1;
               shadow_mode = MODE_DONE;
            end
         end
         MODE_DONE: ;
         default: begin
            if (c == CH_LBRACE) shadow_mode = MODE_BETWEEN;
         end
      endcase
      // final byte closes the document and resets the parser
      if (lst) begin
         if (shadow_mode == MODE_KEY) r.key_end = 1'b1;
         if (shadow_mode != MODE_DONE || r.doc_done) r.doc_done = 1'b1;
         shadow_mode = MODE_SEEK_OPEN;
         shadow_nest = 8'd0;
      end
      r.has_result = r.char_valid | r.key_end | r.doc_done;
      return r;
   endfunction

   // Send one request in bursts, with random gaps between bursts outside calm documents, then log its expectation
   task automatic send_byte(input byte_type b, input bit lst, input bit pinned,
                            input result_type pin);
      result_type want;
      if (burst_left == 0) begin
         if (!calm_doc) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      bytes_sent++;
      want = parse_byte(b, lst);
      if (pinned) want = pin;
      if (want.has_result) add_expect(want);
   endtask

   // Random byte, biased toward JSON punctuation and whitespace
   function automatic byte_type any_byte();
      byte_type specials[12];
      specials = '{CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET, CH_COLON, CH_COMMA,
                    CH_BACKSLASH, CH_QUOTE, CH_SPACE, 8'h09, 8'h0A, 8'h0D};
      if ($urandom_range(0, 1) == 0) return specials[$urandom_range(0, 11)];
      return byte_type'($urandom_range(0, 255));
   endfunction

   // Object or array value with random nesting and filler
   function automatic void nested_value(byte_type open_ch, byte_type close_ch);
      int depth;
      byte_type b;
      depth = 1;
      add_text(open_ch);
      repeat ($urandom_range(0, 8)) begin
         case ($urandom_range(0, 3))
            0: begin
               add_text(open_ch);
               depth++;
            end
            1: begin
               if (depth > 1) begin
                  add_text(close_ch);
                  depth--;
               end
            end
            default: begin
               b = any_byte();
               if (b == open_ch || b == close_ch) b = "x";
               add_text(b);
            end
         endcase
      end
      repeat (depth) add_text(close_ch);
   endfunction

   // Build one random document into doc_text: mostly well formed, some noise or cut short
   function automatic void build_document();
      int kind, nkeys, cut;
      byte_type b;
      doc_text.delete();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         repeat ($urandom_range(1, 20)) add_text(any_byte());
         return;
      end
      repeat ($urandom_range(0, 2)) begin
         b = any_byte();
         add_text((b == CH_LBRACE) ? byte_type'("x") : b);
      end
      add_text(CH_LBRACE);
      nkeys = $urandom_range(0, 4);
      for (int k = 0; k < nkeys; k++) begin
         // whitespace, commas and stray bytes between keys
         repeat ($urandom_range(0, 2)) begin
            b = any_byte();
            if (b == CH_QUOTE || b == CH_RBRACE) b = CH_SPACE;
            add_text(b);
         end
         add_text(CH_QUOTE);
         repeat ($urandom_range(0, 6)) begin
            b = byte_type'($urandom_range(0, 255));
            add_text((b == CH_QUOTE) ? byte_type'("q") : b);
         end
         add_text(CH_QUOTE);
         if ($urandom_range(0, 3) == 0) begin
            b = any_byte();
            add_text((b == CH_COLON) ? CH_SPACE : b);
         end
         add_text(CH_COLON);
         repeat ($urandom_range(0, 2)) add_text(CH_SPACE);
         case ($urandom_range(0, 4))
            0: nested_value(CH_LBRACE, CH_RBRACE);
            1: nested_value(CH_LBRACKET, CH_RBRACKET);
            2: begin
               // string value with escapes
               add_text(CH_QUOTE);
               repeat ($urandom_range(0, 5)) begin
                  if ($urandom_range(0, 4) == 0) begin
                     add_text(CH_BACKSLASH);
                     add_text(any_byte());
                  end else begin
                     b = any_byte();
                     if (b == CH_QUOTE || b == CH_BACKSLASH) b = "s";
                     add_text(b);
                  end
               end
               add_text(CH_QUOTE);
            end
            3: begin
               repeat ($urandom_range(1, 4)) begin
                  b = byte_type'($urandom_range(0, 255));
                  if (b == CH_COMMA || b == CH_RBRACE) b = "5";
                  add_text(b);
               end
            end
            default: ;
         endcase
         if (k < nkeys - 1) add_text(CH_COMMA);
      end
      if ($urandom_range(0, 9) != 0) add_text(CH_RBRACE);
      repeat ($urandom_range(0, 2)) add_text(any_byte());
      // broken document: input ends at a random point
      if (kind == 1) begin
         cut = $urandom_range(1, doc_text.size());
         while (doc_text.size() > cut) void'(doc_text.pop_back());
      end
   endfunction

   // Result receiver stalls: switches at random among four styles
   always @(posedge clock) begin
      if (cycle_count % 256 == 0) stall_style <= $urandom_range(0, 3);
      case (stall_style)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 99) < 60);
         2: rsp_tready <= ((cycle_count >> 1) % 3) != 0;
         default: begin
            if (stall_left != 0) begin
               rsp_tready <= 1'b0;
               stall_left <= stall_left - 1;
            end else begin
               rsp_tready <= 1'b1;
               if ($urandom_range(0, 99) < 10) stall_left <= $urandom_range(4, 20);
            end
         end
      endcase
   end

   // Compare each delivered result with the oldest expectation
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: key_char %h char_valid %b key_end %b doc_done %b",
                        rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]);
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (rsp_tuser[0] === 1'b1) chars_seen++;
            if (rsp_tlast === 1'b1) ends_seen++;
            if (rsp_tuser[1] === 1'b1) dones_seen++;
            if (rsp_tdata !== want.key_char || rsp_tuser[0] !== want.char_valid ||
                rsp_tlast !== want.key_end || rsp_tuser[1] !== want.doc_done) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at cycle %0d: key_char %h/%h char_valid %b/%b %s%b/%b %s%b/%b",
                           cycle_count, want.key_char, rsp_tdata, want.char_valid,
                           rsp_tuser[0], "key_end ", want.key_end, rsp_tlast,
                           "doc_done ", want.doc_done, rsp_tuser[1]);
            end
         end
      end
   end

   // Stimulus
   initial begin
      int drain;
      result_type no_result;
      no_result = '0;

      // Directed documents; pinned rows check values readable at a glance
      directed_rows = '{
         // skipped before the opening brace, right after reset
         '{"x", 1'b0, 1'b1, no_result},
         '{CH_LBRACE, 1'b0, 1'b0, no_result},
         '{CH_QUOTE, 1'b0, 1'b0, no_result},
         // extreme key characters
         '{8'hFF, 1'b0, 1'b1, key_result(8'hFF, 1'b1, 1'b0, 1'b0)},
         '{8'h00, 1'b0, 1'b1, key_result(8'h00, 1'b1, 1'b0, 1'b0)},
         '{CH_QUOTE, 1'b0, 1'b1, key_result(8'h00, 1'b0, 1'b1, 1'b0)},
         '{CH_COLON, 1'b0, 1'b0, no_result},
         // object value, bracket inside ignored
         '{CH_LBRACE, 1'b0, 1'b0, no_result},
         '{CH_LBRACKET, 1'b0, 1'b0, no_result},
         '{CH_RBRACE, 1'b0, 1'b0, no_result},
         '{CH_COMMA, 1'b0, 1'b0, no_result},
         // empty key
         '{CH_QUOTE, 1'b0, 1'b0, no_result},
         '{CH_QUOTE, 1'b0, 1'b1, key_result(8'h00, 1'b0, 1'b1, 1'b0)},
         '{CH_COLON, 1'b0, 1'b0, no_result},
         // scalar closed by the brace, which ends the document
         '{"7", 1'b0, 1'b0, no_result},
         '{CH_RBRACE, 1'b0, 1'b1, key_result(8'h00, 1'b0, 1'b0, 1'b1)},
         // ignored after the end, even as the final byte
         '{"z", 1'b1, 1'b1, no_result},
         // input ends inside a key on a key character
         '{CH_LBRACE, 1'b0, 1'b0, no_result},
         '{CH_QUOTE, 1'b0, 1'b0, no_result},
         '{"b", 1'b1, 1'b1, key_result("b", 1'b1, 1'b1, 1'b1)},
         // array value, input ends between keys
         '{CH_LBRACE, 1'b0, 1'b0, no_result},
         '{CH_QUOTE, 1'b0, 1'b0, no_result},
         '{CH_QUOTE, 1'b0, 1'b0, no_result},
         '{CH_COLON, 1'b0, 1'b0, no_result},
         '{CH_LBRACKET, 1'b0, 1'b0, no_result},
         '{CH_RBRACKET, 1'b1, 1'b1, key_result(8'h00, 1'b0, 1'b0, 1'b1)}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      calm_doc = 1'b0;
      foreach (directed_rows[i])
         send_byte(directed_rows[i].text, directed_rows[i].lst, directed_rows[i].pinned,
                   directed_rows[i].want);
      docs_sent = 3;

      // Random documents; one deep object drives the depth count into saturation
      while (bytes_sent < TARGET_BYTES + $size(directed_rows)) begin
         if (docs_sent == 10) begin
            doc_text.delete();
            add_text(CH_LBRACE);
            add_text(CH_QUOTE);
            add_text("d");
            add_text(CH_QUOTE);
            add_text(CH_COLON);
            repeat (NEST_LIMIT + 45) add_text(CH_LBRACE);
            repeat (NEST_LIMIT + 45) add_text(CH_RBRACE);
            add_text(CH_RBRACE);
         end else begin
            build_document();
         end
         calm_doc = ($urandom_range(0, 3) == 0);
         foreach (doc_text[i])
            send_byte(doc_text[i], i == doc_text.size() - 1, 1'b0, no_result);
         docs_sent++;
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      // Drain outstanding results, then allow the pipeline latency
      drain = 0;
      while (expected_results.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0d expected results never arrived", expected_results.size());
         mismatch_count += expected_results.size();
      end

      $display("%0d documents, %0d bytes sent; %0d results checked", docs_sent, bytes_sent,
               results_checked);
      $display("%0d key characters, %0d key ends, %0d document ends; %0d mismatches",
               chars_seen, ends_seen, dones_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb_json_top_key_extractor: clean");
      end else begin
         $display("tb_json_top_key_extractor: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
+incdir+design
design/jtke_pkg.sv
design/jtke_parser.sv
design/json_top_key_extractor.sv
tb/tb_json_top_key_extractor.sv
